// ----- sv/rfid_tag_pass_detector_macros.svh -----
// Assertion macros for the RFID tag pass detector checker
`ifndef RFID_TAG_PASS_DETECTOR_MACROS_SVH
`define RFID_TAG_PASS_DETECTOR_MACROS_SVH

// same-cycle implication
`define RTP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rtp_pkg.sv -----
// Package: types, widths and codes of the RFID tag pass detector
`timescale 1ns / 1ps
package rtp_pkg;

   localparam int TAG_ENTRIES_DEF = 32;

   localparam int ID_HI_W    = 32;
   localparam int ID_LO_W    = 64;
   localparam int KEY_W      = ID_HI_W + ID_LO_W;
   localparam int LEVEL_W    = 16;
   localparam int STAMP_W    = 48;
   localparam int WINDOW_W   = 24;
   localparam int SPLIT_W    = 16;
   localparam int SPLIT_MS_W = 26;
   localparam int CSR_DATA_W = 24;

   localparam logic [9:0]            MS_PER_S       = 10'd1000;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 24'd2000;
   localparam logic [SPLIT_MS_W-1:0] SPLIT_MS_RESET = 26'd10000;

   typedef enum logic {
      OP_READ = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      EV_MOVING_AWAY = 2'd0,
      EV_MISSING     = 2'd1,
      EV_TABLE_FULL  = 2'd2
   } event_kind_type;

   typedef enum logic {
      CSR_MISSING_WINDOW = 1'b0,
      CSR_SPLIT_TIME     = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic scan_en;
      logic decide;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic scan_done;
      logic pend_valid;
      logic out_free;
   } ctrl_stat_type;

endpackage

// ----- sv/rtp_req_if.sv -----
// Input channel: tag reads and tick beats
`timescale 1ns / 1ps
interface rtp_req_if;
   import rtp_pkg::*;

   logic                       valid;
   logic                       ready;
   opcode_type                 opcode;
   logic [ID_HI_W-1:0]         tag_id_high;
   logic [ID_LO_W-1:0]         tag_id_low;
   logic signed [LEVEL_W-1:0]  level;
   logic [STAMP_W-1:0]         stamp_ms;

   modport source (output valid, opcode, tag_id_high, tag_id_low, level, stamp_ms,
                   input ready);
   modport sink (input valid, opcode, tag_id_high, tag_id_low, level, stamp_ms,
                 output ready);
endinterface

// ----- sv/rtp_rsp_if.sv -----
// Result channel: counted and dropped tag events
`timescale 1ns / 1ps
interface rtp_rsp_if;
   import rtp_pkg::*;

   logic                valid;
   logic                ready;
   event_kind_type      event_kind;
   logic [ID_HI_W-1:0]  out_id_high;
   logic [ID_LO_W-1:0]  out_id_low;
   logic [STAMP_W-1:0]  gap_ms;
   logic                last_in_run;

   modport source (output valid, event_kind, out_id_high, out_id_low, gap_ms, last_in_run,
                   input ready);
   modport sink (input valid, event_kind, out_id_high, out_id_low, gap_ms, last_in_run,
                 output ready);
endinterface

// ----- sv/rtp_csr_if.sv -----
// Configuration write channel
`timescale 1ns / 1ps
interface rtp_csr_if;
   import rtp_pkg::*;

   logic                   valid;
   logic                   ready;
   csr_index_type          index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/rtp_ctrl.sv -----
// Controller: sequences accept, table scan, read decision and result flush
`timescale 1ns / 1ps
module rtp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output rtp_pkg::ctrl_cmd_type cmd,
   input  rtp_pkg::ctrl_stat_type stat
);
   import rtp_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = stat.is_tick ? ST_FLUSH : ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (!stat.pend_valid || stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/rtp_datapath.sv -----
// Datapath: tag table memories, scan pipeline, decision logic, result registers
`timescale 1ns / 1ps
module rtp_datapath #(
   parameter int TAG_ENTRIES = rtp_pkg::TAG_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rtp_pkg::ctrl_cmd_type               cmd,
   output rtp_pkg::ctrl_stat_type              stat,
   input  rtp_pkg::opcode_type                 req_opcode,
   input  logic [rtp_pkg::ID_HI_W-1:0]         req_tag_id_high,
   input  logic [rtp_pkg::ID_LO_W-1:0]         req_tag_id_low,
   input  logic signed [rtp_pkg::LEVEL_W-1:0]  req_level,
   input  logic [rtp_pkg::STAMP_W-1:0]         req_stamp_ms,
   input  logic                                csr_we,
   input  rtp_pkg::csr_index_type              csr_index,
   input  logic [rtp_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rtp_pkg::event_kind_type             rsp_event_kind,
   output logic [rtp_pkg::ID_HI_W-1:0]         rsp_out_id_high,
   output logic [rtp_pkg::ID_LO_W-1:0]         rsp_out_id_low,
   output logic [rtp_pkg::STAMP_W-1:0]         rsp_gap_ms,
   output logic                                rsp_last_in_run
);
   import rtp_pkg::*;

   localparam int IDX_W = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TAG_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TAG_ENTRIES);

   // configuration
   logic [WINDOW_W-1:0]   window_ff;
   logic [SPLIT_MS_W-1:0] split_ms_ff;

   // current item
   opcode_type                op_ff;
   logic [KEY_W-1:0]          key_ff;
   logic signed [LEVEL_W-1:0] level_ff;
   logic [STAMP_W-1:0]        stamp_ff;

   // table
   logic [TAG_ENTRIES-1:0]    used_ff;
   logic [TAG_ENTRIES-1:0]    counted_ff;
   logic [KEY_W-1:0]          key_mem  [TAG_ENTRIES];
   logic [STAMP_W-1:0]        seen_mem [TAG_ENTRIES];
   logic signed [LEVEL_W-1:0] peak_mem [TAG_ENTRIES];
   logic [KEY_W-1:0]          rd_key_ff;
   logic [STAMP_W-1:0]        rd_seen_ff;
   logic signed [LEVEL_W-1:0] rd_peak_ff;

   // scan
   logic [CNT_W-1:0] addr_ff;
   logic             eval_vld_ff;
   logic [IDX_W-1:0] eval_idx_ff;
   logic             found_ff;
   logic [IDX_W-1:0] found_idx_ff;
   logic [STAMP_W-1:0]        found_seen_ff;
   logic signed [LEVEL_W-1:0] found_peak_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;

   // pending and output results
   logic                pend_vld_ff;
   event_kind_type      pend_kind_ff;
   logic [KEY_W-1:0]    pend_key_ff;
   logic [STAMP_W-1:0]  pend_gap_ff;
   logic                rsp_vld_ff;
   event_kind_type      rsp_kind_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [STAMP_W-1:0]  rsp_gap_ff;
   logic                rsp_last_ff;

   logic [IDX_W-1:0]   rd_addr;
   logic               rd_issue;
   logic [STAMP_W-1:0] window_ext;
   logic [STAMP_W-1:0] split_ext;
   logic [STAMP_W-1:0] ev_gap;
   logic               ev_used;
   logic               ev_counted;
   logic               ev_tick;
   logic               ev_miss;
   logic               ev_clear;
   logic               ev_match;
   logic               ev_free;
   logic               stall;
   logic               scan_take;
   logic               push_mid;
   logic               flush_go;
   logic               out_free;
   logic [STAMP_W-1:0] dec_gap;
   logic               dec_new;
   logic               dec_seen;
   logic               dec_peak;
   logic               dec_count;
   logic               dec_full;
   logic [IDX_W-1:0]   wr_idx;

   assign window_ext = {{(STAMP_W - WINDOW_W){1'b0}}, window_ff};
   assign split_ext  = {{(STAMP_W - SPLIT_MS_W){1'b0}}, split_ms_ff};
   assign out_free   = !rsp_vld_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WINDOW_RESET;
         split_ms_ff <= SPLIT_MS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MISSING_WINDOW: window_ff <= csr_data[WINDOW_W-1:0];
            CSR_SPLIT_TIME: begin
               split_ms_ff <= SPLIT_MS_W'(csr_data[SPLIT_W-1:0]) * SPLIT_MS_W'(MS_PER_S);
            end
            default: window_ff <= window_ff;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_opcode;
         key_ff   <= {req_tag_id_high, req_tag_id_low};
         level_ff <= req_level;
         stamp_ff <= req_stamp_ms;
      end
   end

   // evaluation stage
   always_comb begin
      ev_used    = used_ff[eval_idx_ff];
      ev_counted = counted_ff[eval_idx_ff];
      ev_gap     = stamp_ff - rd_seen_ff;
      ev_tick    = eval_vld_ff && (op_ff == OP_TICK) && ev_used;
      ev_miss    = ev_tick && !ev_counted && (ev_gap > window_ext);
      ev_clear   = ev_tick && ev_counted && (ev_gap > split_ext);
      ev_match   = eval_vld_ff && (op_ff == OP_READ) && ev_used && !found_ff
                   && (rd_key_ff == key_ff);
      ev_free    = eval_vld_ff && (op_ff == OP_READ) && !ev_used && !free_ff;
      stall      = cmd.scan_en && ev_miss && pend_vld_ff && !out_free;
      scan_take  = cmd.scan_en && ev_miss && !stall;
      push_mid   = scan_take && pend_vld_ff;
      flush_go   = cmd.flush && pend_vld_ff && out_free;
      rd_addr    = addr_ff[IDX_W-1:0];
      rd_issue   = cmd.scan_en && !stall && (addr_ff != LAST_CNT);
   end

   // read decision
   always_comb begin
      dec_gap   = stamp_ff - found_seen_ff;
      dec_new   = 1'b0;
      dec_seen  = 1'b0;
      dec_peak  = 1'b0;
      dec_count = 1'b0;
      dec_full  = 1'b0;
      if (cmd.decide) begin
         priority if (!found_ff) begin
            dec_new  = free_ff;
            dec_full = !free_ff;
         end else if (counted_ff[found_idx_ff]) begin
            dec_seen = 1'b1;
         end else if (dec_gap > window_ext) begin
            // stale read, left for the tick
            dec_seen = 1'b0;
         end else if (found_peak_ff < level_ff) begin
            dec_peak = 1'b1;
         end else begin
            dec_count = 1'b1;
         end
      end
      wr_idx = dec_new ? free_idx_ff : found_idx_ff;
   end

   // scan pipeline control
   always_ff @(posedge clock) begin
      if (reset || cmd.accept) begin
         addr_ff     <= '0;
         eval_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
      end else begin
         if (rd_issue) begin
            addr_ff <= addr_ff + CNT_W'(1);
         end
         if (cmd.scan_en && !stall) begin
            eval_vld_ff <= rd_issue;
         end
         if (cmd.scan_en && ev_match) begin
            found_ff <= 1'b1;
         end
         if (cmd.scan_en && ev_free) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_en && !stall) begin
         eval_idx_ff <= rd_addr;
      end
      if (cmd.scan_en && ev_match) begin
         found_idx_ff  <= eval_idx_ff;
         found_seen_ff <= rd_seen_ff;
         found_peak_ff <= rd_peak_ff;
      end
      if (cmd.scan_en && ev_free) begin
         free_idx_ff <= eval_idx_ff;
      end
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (dec_new) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (dec_new || dec_seen || dec_peak) begin
         seen_mem[wr_idx] <= stamp_ff;
      end
      if (dec_new || dec_peak) begin
         peak_mem[wr_idx] <= level_ff;
      end
      if (rd_issue) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_seen_ff <= seen_mem[rd_addr];
         rd_peak_ff <= peak_mem[rd_addr];
      end
   end

   // entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         counted_ff <= '0;
      end else begin
         if (cmd.scan_en && ev_clear) begin
            used_ff[eval_idx_ff]    <= 1'b0;
            counted_ff[eval_idx_ff] <= 1'b0;
         end
         if (scan_take) begin
            counted_ff[eval_idx_ff] <= 1'b1;
         end
         if (dec_new) begin
            used_ff[free_idx_ff]    <= 1'b1;
            counted_ff[free_idx_ff] <= 1'b0;
         end
         if (dec_count) begin
            counted_ff[found_idx_ff] <= 1'b1;
         end
      end
   end

   // pending result: held until the next result or the end of the item decides last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (scan_take || dec_full || dec_count) begin
         pend_vld_ff <= 1'b1;
      end else if (flush_go) begin
         pend_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_take) begin
         pend_kind_ff <= EV_MISSING;
         pend_key_ff  <= rd_key_ff;
         pend_gap_ff  <= ev_gap;
      end else if (dec_full) begin
         pend_kind_ff <= EV_TABLE_FULL;
         pend_key_ff  <= key_ff;
         pend_gap_ff  <= '0;
      end else if (dec_count) begin
         pend_kind_ff <= EV_MOVING_AWAY;
         pend_key_ff  <= key_ff;
         pend_gap_ff  <= dec_gap;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (push_mid || flush_go) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_mid || flush_go) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_key_ff  <= pend_key_ff;
         rsp_gap_ff  <= pend_gap_ff;
         rsp_last_ff <= flush_go;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_out_id_high = rsp_key_ff[KEY_W-1:ID_LO_W];
   assign rsp_out_id_low  = rsp_key_ff[ID_LO_W-1:0];
   assign rsp_gap_ms      = rsp_gap_ff;
   assign rsp_last_in_run = rsp_last_ff;

   assign stat.is_tick    = (op_ff == OP_TICK);
   assign stat.scan_done  = (addr_ff == LAST_CNT) && !eval_vld_ff;
   assign stat.pend_valid = pend_vld_ff;
   assign stat.out_free   = out_free;

endmodule

// ----- sv/rfid_tag_pass_detector.sv -----
// Top level: the next beat is accepted once the scan, decision (reads only) and flush of the last
// beat are done; flush waits while rsp is held. A read's result, if any, is output at flush.
// The scan reads one table entry per cycle unless stalled and sets the rate.
// A tick beat stalls its scan while a finished result and a pending result both wait.
// Reset (synchronous) clears all entry valid and counted flags and restores both registers;
// there is no clearing pass, so the first item may be accepted right after reset.
`timescale 1ns / 1ps
module rfid_tag_pass_detector #(
   parameter int TAG_ENTRIES = rtp_pkg::TAG_ENTRIES_DEF
) (
   input logic      clock,
   input logic      reset,
   rtp_req_if.sink  req_chan,
   rtp_rsp_if.source rsp_chan,
   rtp_csr_if.sink  csr_chan
);
   import rtp_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   assign csr_chan.ready = 1'b1;

   rtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rtp_datapath #(
      .TAG_ENTRIES (TAG_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_chan.opcode),
      .req_tag_id_high (req_chan.tag_id_high),
      .req_tag_id_low  (req_chan.tag_id_low),
      .req_level       (req_chan.level),
      .req_stamp_ms    (req_chan.stamp_ms),
      .csr_we          (csr_chan.valid && csr_chan.ready),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_event_kind  (rsp_chan.event_kind),
      .rsp_out_id_high (rsp_chan.out_id_high),
      .rsp_out_id_low  (rsp_chan.out_id_low),
      .rsp_gap_ms      (rsp_chan.gap_ms),
      .rsp_last_in_run (rsp_chan.last_in_run)
   );

endmodule

// ----- sv/rtp_checker.sv -----
// Port-level checker for the RFID tag pass detector, with its bind
`timescale 1ns / 1ps
`include "rfid_tag_pass_detector_macros.svh"
module rtp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input rtp_pkg::event_kind_type      rsp_event_kind,
   input logic [rtp_pkg::ID_HI_W-1:0]  rsp_out_id_high,
   input logic [rtp_pkg::ID_LO_W-1:0]  rsp_out_id_low,
   input logic [rtp_pkg::STAMP_W-1:0]  rsp_gap_ms,
   input logic                         rsp_last_in_run
);
   import rtp_pkg::*;

   `RTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_out_id_high) && $stable(rsp_out_id_low) && $stable(rsp_gap_ms) && $stable(rsp_last_in_run), "rsp beat changed while stalled")
   `RTP_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "req accepted while an item is in work")
   `RTP_ASSERT_IMPL(a_read_last, clock, reset, rsp_valid && (rsp_event_kind == EV_MOVING_AWAY || rsp_event_kind == EV_TABLE_FULL), rsp_last_in_run, "read result not marked last")
   `RTP_ASSERT_IMPL(a_full_gap, clock, reset, rsp_valid && rsp_event_kind == EV_TABLE_FULL, rsp_gap_ms == '0, "table full drop with nonzero gap")

endmodule

bind rfid_tag_pass_detector rtp_checker u_rtp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_event_kind  (rsp_chan.event_kind),
   .rsp_out_id_high (rsp_chan.out_id_high),
   .rsp_out_id_low  (rsp_chan.out_id_low),
   .rsp_gap_ms      (rsp_chan.gap_ms),
   .rsp_last_in_run (rsp_chan.last_in_run)
);

// ----- dv/tb_rfid_tag_pass_detector.sv -----
// Testbench for the RFID tag pass detector: directed and random beats checked against a tag table model
`timescale 1ns / 1ps
module tb_rfid_tag_pass_detector;
   import rtp_pkg::*;

   localparam int TAG_ENTRIES  = TAG_ENTRIES_DEF;
   localparam int SETTLE_CYCLES = 2 * (TAG_ENTRIES + 5);
   localparam int ID_POOL      = 10;
   localparam int BURST_TAGS   = 40;

   typedef struct {
      opcode_type               op;
      logic [ID_HI_W-1:0]       hi;
      logic [ID_LO_W-1:0]       lo;
      logic signed [LEVEL_W-1:0] lvl;
      logic [STAMP_W-1:0]       stamp;
   } tag_beat_type;

   typedef struct {
      event_kind_type      kind;
      logic [ID_HI_W-1:0]  hi;
      logic [ID_LO_W-1:0]  lo;
      logic [STAMP_W-1:0]  gap;
      logic                last;
   } tag_event_type;

   logic clock;
   logic reset;
   bit   quiet = 1'b0;
   int   failures = 0;

   rtp_req_if req_if();
   rtp_rsp_if rsp_if();
   rtp_csr_if csr_if();

   rfid_tag_pass_detector #(
      .TAG_ENTRIES(TAG_ENTRIES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // tag table model
   logic                      tbl_used    [TAG_ENTRIES];
   logic [ID_HI_W-1:0]        tbl_hi      [TAG_ENTRIES];
   logic [ID_LO_W-1:0]        tbl_lo      [TAG_ENTRIES];
   logic [STAMP_W-1:0]        tbl_seen    [TAG_ENTRIES];
   logic signed [LEVEL_W-1:0] tbl_peak    [TAG_ENTRIES];
   logic                      tbl_counted [TAG_ENTRIES];
   logic [WINDOW_W-1:0]       cfg_window;
   logic [SPLIT_W-1:0]        cfg_split;

   tag_event_type expected_events[$];
   logic [STAMP_W-1:0] now_ms;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic predict_tag_events(input tag_beat_type b);
      tag_event_type run[$];
      tag_event_type ev;
      int found;
      int free_slot;
      logic [STAMP_W-1:0] gap;
      logic [STAMP_W-1:0] split_ms;
      found = -1;
      free_slot = -1;
      split_ms = 48'(cfg_split) * 48'(MS_PER_S);
      if (b.op == OP_TICK) begin
         for (int i = 0; i < TAG_ENTRIES; i++) begin
            if (tbl_used[i]) begin
               gap = b.stamp - tbl_seen[i];
               if (tbl_counted[i]) begin
                  if (gap > split_ms) begin
                     tbl_used[i] = 1'b0;
                     tbl_counted[i] = 1'b0;
                     tbl_seen[i] = '0;
                  end
               end else if (gap > 48'(cfg_window)) begin
                  tbl_counted[i] = 1'b1;
                  ev = '{EV_MISSING, tbl_hi[i], tbl_lo[i], gap, 1'b0};
                  run.push_back(ev);
               end
            end
         end
      end else begin
         for (int i = 0; i < TAG_ENTRIES; i++) begin
            if (tbl_used[i]) begin
               if (found < 0 && tbl_hi[i] == b.hi && tbl_lo[i] == b.lo) found = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (found < 0) begin
            if (free_slot < 0) begin
               ev = '{EV_TABLE_FULL, b.hi, b.lo, '0, 1'b0};
               run.push_back(ev);
            end else begin
               tbl_used[free_slot] = 1'b1;
               tbl_hi[free_slot] = b.hi;
               tbl_lo[free_slot] = b.lo;
               tbl_peak[free_slot] = b.lvl;
               tbl_seen[free_slot] = b.stamp;
               tbl_counted[free_slot] = 1'b0;
            end
         end else if (tbl_counted[found]) begin
            tbl_seen[found] = b.stamp;
         end else begin
            gap = b.stamp - tbl_seen[found];
            if (gap > 48'(cfg_window)) begin
               // stale: the sweep will count it
            end else if (tbl_peak[found] < b.lvl) begin
               tbl_peak[found] = b.lvl;
               tbl_seen[found] = b.stamp;
            end else begin
               tbl_counted[found] = 1'b1;
               ev = '{EV_MOVING_AWAY, b.hi, b.lo, gap, 1'b0};
               run.push_back(ev);
            end
         end
      end
      for (int k = 0; k < run.size(); k++) begin
         ev = run[k];
         ev.last = (k == run.size() - 1);
         expected_events.push_back(ev);
      end
   endtask

   task automatic check_field(input string name, input logic [95:0] exp_v,
                              input logic [95:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= 21);
   end

   always @(posedge clock) begin
      tag_event_type exp_ev;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d id %h_%h gap %0h",
                     $time, rsp_if.event_kind, rsp_if.out_id_high, rsp_if.out_id_low,
                     rsp_if.gap_ms);
            failures++;
         end else begin
            exp_ev = expected_events.pop_front();
            check_field("event_kind", exp_ev.kind, rsp_if.event_kind);
            check_field("out_id_high", exp_ev.hi, rsp_if.out_id_high);
            check_field("out_id_low", exp_ev.lo, rsp_if.out_id_low);
            check_field("gap_ms", exp_ev.gap, rsp_if.gap_ms);
            check_field("last_in_run", exp_ev.last, rsp_if.last_in_run);
         end
      end
   end

   task automatic send_beat(input tag_beat_type b);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.opcode      <= b.op;
      req_if.tag_id_high <= b.hi;
      req_if.tag_id_low  <= b.lo;
      req_if.level       <= b.lvl;
      req_if.stamp_ms    <= b.stamp;
      do @(posedge clock); while (!req_if.ready);
      predict_tag_events(b);
   endtask

   task automatic send_read(input logic [ID_HI_W-1:0] hi, input logic [ID_LO_W-1:0] lo,
                            input logic signed [LEVEL_W-1:0] lvl,
                            input logic [STAMP_W-1:0] stamp);
      tag_beat_type b;
      b = '{OP_READ, hi, lo, lvl, stamp};
      send_beat(b);
   endtask

   task automatic send_tick(input logic [STAMP_W-1:0] stamp);
      tag_beat_type b;
      b = '{OP_TICK, $urandom, {$urandom, $urandom}, 16'($urandom), stamp};
      send_beat(b);
   endtask

   // wait until every expected event is out and the last beat has left the scan
   task automatic settle_block();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_MISSING_WINDOW) cfg_window = value[WINDOW_W-1:0];
      else cfg_split = value[SPLIT_W-1:0];
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [WINDOW_W-1:0] win, input logic [SPLIT_W-1:0] split_s);
      settle_block();
      csr_write(CSR_MISSING_WINDOW, win);
      csr_write(CSR_SPLIT_TIME, {8'd0, split_s});
   endtask

   function automatic int clamp_level(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   task automatic test_pass_by_peak();
      send_read(32'h0000_0001, 64'h0000_0000_0000_00A1, -16'sd100, 48'd1000);
      send_read(32'h0000_0001, 64'h0000_0000_0000_00A1, -16'sd50, 48'd1500);
      send_read(32'h0000_0001, 64'h0000_0000_0000_00A1, -16'sd50, 48'd2000);
      send_read(32'h0000_0001, 64'h0000_0000_0000_00A1, 16'sd0, 48'd2500);
   endtask

   task automatic test_stale_and_missing();
      send_read(32'h0000_0002, 64'h0000_0000_0000_00B2, 16'sd10, 48'd3000);
      send_tick(48'd5000);
      send_read(32'h0000_0002, 64'h0000_0000_0000_00B2, 16'sd20, 48'd5001);
      send_tick(48'd5001);
   endtask

   task automatic test_split_and_reuse();
      send_tick(48'd12501);
      send_tick(48'd15001);
      send_read(32'h0000_0001, 64'h0000_0000_0000_00A1, 16'sd5, 48'd15002);
      send_read(32'h0000_0001, 64'h0000_0000_0000_00A1, 16'sd4, 48'd15003);
   endtask

   task automatic test_field_extremes();
      set_config(24'd0, 16'd0);
      send_read('1, '1, 16'sh7FFF, 48'hFFFF_FFFF_FFFF);
      send_read('1, '1, -16'sh8000, 48'hFFFF_FFFF_FFFF);
      send_read('0, '0, -16'sh8000, 48'd0);
      send_read('0, '0, 16'sh7FFF, 48'd0);
      send_tick(48'd0);
      set_config(24'hFF_FFFF, 16'hFFFF);
      send_read('0, '0, 16'sh7FFF, 48'hFF_FFFF);
      send_tick(48'hFF_FFFF + 48'd65535000);
      send_tick(48'hFF_FFFF + 48'd65535001);
   endtask

   task automatic test_table_full();
      logic [ID_HI_W-1:0] burst_hi [BURST_TAGS];
      logic [ID_LO_W-1:0] burst_lo [BURST_TAGS];
      int j;
      set_config(WINDOW_RESET, 16'd10);
      now_ms = 48'({$urandom, $urandom});
      send_tick(now_ms);
      send_tick(now_ms);
      for (int k = 0; k < BURST_TAGS; k++) begin
         j = k;
         if (k > 0 && $urandom_range(7) == 0) j = $urandom_range(k - 1);
         if (j == k) begin
            burst_hi[k] = $urandom;
            burst_lo[k] = {$urandom, $urandom};
         end
         send_read(burst_hi[j], burst_lo[j], 16'($urandom), now_ms);
      end
      send_tick(now_ms + 48'd2001);
      send_tick(now_ms + 48'd12002);
   endtask

   task automatic run_random_phase(input logic [WINDOW_W-1:0] win,
                                   input logic [SPLIT_W-1:0] split_s, input int count);
      logic [ID_HI_W-1:0] pool_hi [ID_POOL];
      logic [ID_LO_W-1:0] pool_lo [ID_POOL];
      int pool_lvl [ID_POOL];
      tag_beat_type b;
      int unsigned w;
      int unsigned split_ms;
      int unsigned adv;
      int r;
      int k;
      set_config(win, split_s);
      w = win;
      split_ms = int'(split_s) * 1000;
      now_ms = 48'({$urandom, $urandom});
      for (int i = 0; i < ID_POOL; i++) begin
         pool_hi[i] = $urandom;
         pool_lo[i] = {$urandom, $urandom};
         pool_lvl[i] = $signed(16'($urandom));
      end
      repeat (count) begin
         r = $urandom_range(99);
         k = $urandom_range(ID_POOL - 1);
         b = '{OP_READ, $urandom, {$urandom, $urandom}, 16'($urandom), now_ms};
         if (r < 12) begin
            b.op = OP_TICK;
            case ($urandom_range(2))
               0: adv = $urandom_range(0, w / 2 + 1);
               1: adv = $urandom_range(w, 2 * w + 1);
               default: adv = $urandom_range(split_ms, split_ms + w + 1);
            endcase
            now_ms = now_ms + 48'(adv);
            b.stamp = now_ms;
         end else if (r < 82) begin
            r = $urandom_range(99);
            if (r < 65) pool_lvl[k] = clamp_level(pool_lvl[k] + $urandom_range(1, 800));
            else if (r < 80) pool_lvl[k] = clamp_level(pool_lvl[k] - $urandom_range(1, 800));
            now_ms = now_ms + 48'($urandom_range(0, w / 6 + 1));
            b.hi = pool_hi[k];
            b.lo = pool_lo[k];
            b.lvl = 16'(pool_lvl[k]);
            b.stamp = now_ms;
         end else if (r < 92) begin
            // fresh tag, often kept for later reads
            if ($urandom_range(1)) begin
               pool_hi[k] = b.hi;
               pool_lo[k] = b.lo;
               pool_lvl[k] = b.lvl;
            end
         end else begin
            // out-of-order stamp on a known tag
            b.hi = pool_hi[k];
            b.lo = pool_lo[k];
            b.stamp = 48'({$urandom, $urandom});
         end
         send_beat(b);
      end
   endtask

   initial begin
      req_if.valid       <= 1'b0;
      req_if.opcode      <= OP_READ;
      req_if.tag_id_high <= '0;
      req_if.tag_id_low  <= '0;
      req_if.level       <= '0;
      req_if.stamp_ms    <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= CSR_MISSING_WINDOW;
      csr_if.data        <= '0;
      reset              <= 1'b1;
      cfg_window = WINDOW_RESET;
      cfg_split  = 16'd10;
      for (int i = 0; i < TAG_ENTRIES; i++) begin
         tbl_used[i] = 1'b0;
         tbl_seen[i] = '0;
         tbl_counted[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pass_by_peak();
      test_stale_and_missing();
      test_split_and_reuse();
      test_field_extremes();
      run_random_phase(WINDOW_RESET, 16'd10, 110);
      run_random_phase(24'd0, 16'd0, 90);
      quiet = 1'b1;
      run_random_phase(24'hFF_FFFF, 16'hFFFF, 100);
      quiet = 1'b0;
      test_table_full();
      run_random_phase(24'($urandom_range(1, 5000)), 16'($urandom_range(0, 15)), 110);

      settle_block();
      if (failures == 0) begin
         $display("tb_rfid_tag_pass_detector passed");
      end else begin
         $display("tb_rfid_tag_pass_detector failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_rfid_tag_pass_detector failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/rtp_pkg.sv
sv/rtp_req_if.sv
sv/rtp_rsp_if.sv
sv/rtp_csr_if.sv
sv/rtp_ctrl.sv
sv/rtp_datapath.sv
sv/rfid_tag_pass_detector.sv
sv/rtp_checker.sv
dv/tb_rfid_tag_pass_detector.sv
